[rtl/core/tpi_pkg.sv]
// shared types, constants and tables for the turtle path interpreter
`timescale 1ns / 1ps
package tpi_pkg;

  localparam int unsigned StackDepth  = 64;
  localparam int unsigned StackAw     = (StackDepth > 1) ? $clog2(StackDepth) : 1;
  localparam int unsigned CntW        = $clog2(StackDepth + 1);
  localparam int unsigned CordicSteps = 16;
  localparam int unsigned StepW       = $clog2(CordicSteps + 1);
  localparam int unsigned QueueDepth  = 2;
  localparam int unsigned CfgAw       = 2;

  localparam logic [7:0] SymPlus   = 8'h2B;
  localparam logic [7:0] SymMinus  = 8'h2D;
  localparam logic [7:0] SymPush   = 8'h5B;
  localparam logic [7:0] SymPop    = 8'h5D;

  localparam logic [CfgAw-1:0] RegStdLength = 2'd0;
  localparam logic [CfgAw-1:0] RegStdAngle  = 2'd1;
  localparam logic [CfgAw-1:0] RegStartX    = 2'd2;
  localparam logic [CfgAw-1:0] RegStartY    = 2'd3;

  localparam logic [1:0] ErrNone      = 2'd0;
  localparam logic [1:0] ErrUnderflow = 2'd1;
  localparam logic [1:0] ErrOverflow  = 2'd2;

  localparam logic signed [35:0] CordicGain = 36'sd652032874;

  typedef enum logic [2:0] {
    OpIgnore,
    OpDraw,
    OpTurnLeft,
    OpTurnRight,
    OpPush,
    OpPop
  } op_e;

  typedef struct packed {
    logic                begin_req;
    op_e                 op;
    logic [7:0]          symbol;
    logic                has_value;
    logic signed [23:0]  value;
  } cmd_t;

  typedef enum logic [2:0] {
    StIdle,
    StMul,
    StCordic,
    StProd,
    StSum,
    StPop,
    StOut
  } state_e;

  function automatic logic signed [35:0] atan_lut(input logic [4:0] i);
    logic signed [35:0] r;
    case (i)
      5'd0:  r = 36'sh020000000;
      5'd1:  r = 36'sh012E4051E;
      5'd2:  r = 36'sh009FB385B;
      5'd3:  r = 36'sh0051111D4;
      5'd4:  r = 36'sh0028B0D43;
      5'd5:  r = 36'sh00145D7E1;
      5'd6:  r = 36'sh000A2F61E;
      5'd7:  r = 36'sh000517C55;
      5'd8:  r = 36'sh00028BE53;
      5'd9:  r = 36'sh000145F2F;
      5'd10: r = 36'sh0000A2F98;
      5'd11: r = 36'sh0000517CC;
      5'd12: r = 36'sh000028BE6;
      5'd13: r = 36'sh0000145F3;
      5'd14: r = 36'sh00000A2FA;
      5'd15: r = 36'sh00000517D;
      5'd16: r = 36'sh0000028BE;
      5'd17: r = 36'sh00000145F;
      5'd18: r = 36'sh000000A30;
      5'd19: r = 36'sh000000518;
      5'd20: r = 36'sh00000028C;
      5'd21: r = 36'sh000000146;
      5'd22: r = 36'sh0000000A3;
      5'd23: r = 36'sh000000051;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

[rtl/core/tpi_front.sv]
// front end: accepts symbols, classifies them and queues commands
`timescale 1ns / 1ps
module tpi_front import tpi_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               begin_req_i,
  input  logic [7:0]         symbol_i,
  input  logic               has_value_i,
  input  logic signed [23:0] value_i,
  output logic               cmd_valid_o,
  input  logic               cmd_ready_i,
  output cmd_t               cmd_o
);

  localparam int unsigned QAw = $clog2(QueueDepth);

  cmd_t             mem_q [QueueDepth];
  logic [QAw-1:0]   wr_q, wr_d, rd_q, rd_d;
  logic [QAw:0]     cnt_q, cnt_d;
  cmd_t             cmd_in;
  logic             push, pop;

  always_comb begin
    cmd_in.begin_req = begin_req_i;
    cmd_in.symbol    = symbol_i;
    cmd_in.has_value = has_value_i;
    cmd_in.value     = value_i;
    if ((symbol_i >= 8'h41 && symbol_i <= 8'h5A) || (symbol_i >= 8'h61 && symbol_i <= 8'h7A)) begin
      cmd_in.op = OpDraw;
    end else if (symbol_i == SymPlus) begin
      cmd_in.op = OpTurnLeft;
    end else if (symbol_i == SymMinus) begin
      cmd_in.op = OpTurnRight;
    end else if (symbol_i == SymPush) begin
      cmd_in.op = OpPush;
    end else if (symbol_i == SymPop) begin
      cmd_in.op = OpPop;
    end else begin
      cmd_in.op = OpIgnore;
    end
  end

  assign in_ready    = (cnt_q != (QAw+1)'(QueueDepth));
  assign cmd_valid_o = (cnt_q != '0);
  assign cmd_o       = mem_q[rd_q];
  assign push        = in_valid && in_ready;
  assign pop         = cmd_valid_o && cmd_ready_i;

  always_comb begin
    wr_d  = push ? QAw'((wr_q + 1'b1) % QueueDepth) : wr_q;
    rd_d  = pop  ? QAw'((rd_q + 1'b1) % QueueDepth) : rd_q;
    cnt_d = cnt_q + (QAw+1)'(push) - (QAw+1)'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= cmd_in;
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (QAw+1)'(QueueDepth)) else $error("queue count out of range");
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q == (QAw+1)'(QueueDepth) |-> !push) else $error("push into full queue");
  a_cnt_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push && !pop |=> cnt_q == $past(cnt_q) + 1'b1) else $error("queue count lost a push");

endmodule

[rtl/core/tpi_back.sv]
// back end: executes turtle commands with a cordic and a push/pop stack
`timescale 1ns / 1ps
module tpi_back import tpi_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cmd_valid_i,
  output logic               cmd_ready_o,
  input  cmd_t               cmd_i,
  input  logic [23:0]        std_length_i,
  input  logic [15:0]        std_angle_i,
  input  logic signed [31:0] start_x_i,
  input  logic signed [31:0] start_y_i,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] from_x_o,
  output logic signed [31:0] from_y_o,
  output logic signed [31:0] to_x_o,
  output logic signed [31:0] to_y_o,
  output logic [7:0]         drawn_symbol_o,
  output logic               visible_o,
  output logic [1:0]         error_o
);

  state_e state_q, state_d;
  logic signed [31:0] pos_x_q, pos_x_d, pos_y_q, pos_y_d;
  logic [15:0]        head_q, head_d;
  logic [CntW-1:0]    depth_q, depth_d;
  cmd_t               cmd_q, cmd_d;
  logic signed [31:0] len_q, len_d;
  logic signed [35:0] cx_q, cx_d, cy_q, cy_d, cz_q, cz_d;
  logic               flip_q, flip_d;
  logic [StepW-1:0]   step_q, step_d;
  logic signed [63:0] px_q, px_d, py_q, py_d;
  logic               ov_q, ov_d;
  logic signed [31:0] ofx_q, ofx_d, ofy_q, ofy_d, otx_q, otx_d, oty_q, oty_d;
  logic [7:0]         osym_q, osym_d;
  logic               ovis_q, ovis_d;
  logic [1:0]         oerr_q, oerr_d;

  logic [63:0]        spos_mem [StackDepth];
  logic [15:0]        shead_mem [StackDepth];
  logic [63:0]        spos_rd_q;
  logic [15:0]        shead_rd_q;
  logic               st_we;
  logic [StackAw-1:0] st_wa, st_ra;

  logic signed [31:0] bx, by;
  logic [15:0]        bh;
  logic [CntW-1:0]    bd;
  logic signed [47:0] lprod;
  logic signed [35:0] z0, dx, dy;
  logic signed [65:0] sx, sy;
  logic signed [33:0] nx, ny;

  assign out_valid      = ov_q;
  assign from_x_o       = ofx_q;
  assign from_y_o       = ofy_q;
  assign to_x_o         = otx_q;
  assign to_y_o         = oty_q;
  assign drawn_symbol_o = osym_q;
  assign visible_o      = ovis_q;
  assign error_o        = oerr_q;

  function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
    if (v > 34'sh07FFFFFFF) return 32'sh7FFFFFFF;
    if (v < -34'sh080000000) return -32'sh80000000;
    return v[31:0];
  endfunction

  always_comb begin
    state_d = state_q;
    pos_x_d = pos_x_q; pos_y_d = pos_y_q; head_d = head_q; depth_d = depth_q;
    cmd_d = cmd_q; len_d = len_q; cx_d = cx_q; cy_d = cy_q; cz_d = cz_q;
    flip_d = flip_q; step_d = step_q; px_d = px_q; py_d = py_q;
    ov_d = ov_q; ofx_d = ofx_q; ofy_d = ofy_q; otx_d = otx_q; oty_d = oty_q;
    osym_d = osym_q; ovis_d = ovis_q; oerr_d = oerr_q;
    cmd_ready_o = 1'b0;
    st_we = 1'b0;
    st_wa = depth_q[StackAw-1:0];
    st_ra = StackAw'(depth_q - 1'b1);
    bx = cmd_i.begin_req ? start_x_i : pos_x_q;
    by = cmd_i.begin_req ? start_y_i : pos_y_q;
    bh = cmd_i.begin_req ? 16'd0 : head_q;
    bd = cmd_i.begin_req ? '0 : depth_q;
    lprod = $signed(cmd_q.value) * $signed({1'b0, std_length_i});
    z0 = {{4{head_q[15]}}, head_q, 16'd0};
    dx = cy_q >>> step_q;
    dy = cx_q >>> step_q;
    sx = $signed({{2{len_q[31]}}, len_q}) * cx_q + 66'sd536870912;
    sy = $signed({{2{len_q[31]}}, len_q}) * cy_q + 66'sd536870912;
    nx = $signed({{2{pos_x_q[31]}}, pos_x_q}) + px_q[33:0];
    ny = $signed({{2{pos_y_q[31]}}, pos_y_q}) - py_q[33:0];
    if (ov_q && out_ready) ov_d = 1'b0;
    case (state_q)
      StIdle: begin
        if (cmd_valid_i && (!ov_q || out_ready)) begin
          cmd_ready_o = 1'b1;
          cmd_d = cmd_i;
          pos_x_d = bx; pos_y_d = by; head_d = bh; depth_d = bd;
          case (cmd_i.op)
            OpDraw: state_d = StMul;
            OpTurnLeft: head_d = bh + (cmd_i.has_value ? cmd_i.value[15:0] : std_angle_i);
            OpTurnRight: head_d = bh - (cmd_i.has_value ? cmd_i.value[15:0] : std_angle_i);
            OpPush: begin
              if (bd >= CntW'(StackDepth)) begin
                ov_d = 1'b1; ofx_d = bx; ofy_d = by; otx_d = bx; oty_d = by;
                osym_d = cmd_i.symbol; ovis_d = 1'b0; oerr_d = ErrOverflow;
              end else begin
                st_we = 1'b1;
                st_wa = bd[StackAw-1:0];
                depth_d = bd + 1'b1;
              end
            end
            OpPop: begin
              if (bd == '0) begin
                ov_d = 1'b1; ofx_d = bx; ofy_d = by; otx_d = bx; oty_d = by;
                osym_d = cmd_i.symbol; ovis_d = 1'b0; oerr_d = ErrUnderflow;
              end else begin
                st_ra = StackAw'(bd - 1'b1);
                depth_d = bd - 1'b1;
                state_d = StPop;
              end
            end
            default: ;
          endcase
        end
      end
      StPop: begin
        pos_x_d = spos_rd_q[63:32];
        pos_y_d = spos_rd_q[31:0];
        head_d = shead_rd_q;
        state_d = StIdle;
      end
      StMul: begin
        len_d = cmd_q.has_value ? 32'((lprod + 48'sd32768) >>> 16)
                                : $signed({8'd0, std_length_i});
        cx_d = CordicGain; cy_d = '0; flip_d = 1'b0;
        cz_d = z0;
        if (z0 > 36'sh040000000) begin
          cz_d = z0 - 36'sh080000000; flip_d = 1'b1;
        end else if (z0 < -36'sh040000000) begin
          cz_d = z0 + 36'sh080000000; flip_d = 1'b1;
        end
        step_d = '0;
        state_d = StCordic;
      end
      StCordic: begin
        if (step_q == StepW'(CordicSteps)) begin
          if (flip_q) begin cx_d = -cx_q; cy_d = -cy_q; end
          state_d = StProd;
        end else begin
          if (!cz_q[35]) begin
            cx_d = cx_q - dx; cy_d = cy_q + dy; cz_d = cz_q - atan_lut(5'(step_q));
          end else begin
            cx_d = cx_q + dx; cy_d = cy_q - dy; cz_d = cz_q + atan_lut(5'(step_q));
          end
          step_d = step_q + 1'b1;
        end
      end
      StProd: begin
        px_d = 64'(sx >>> 30);
        py_d = 64'(sy >>> 30);
        state_d = StSum;
      end
      StSum: begin
        if (!ov_q || out_ready) begin
          ov_d = 1'b1;
          ofx_d = pos_x_q; ofy_d = pos_y_q;
          otx_d = sat32(nx); oty_d = sat32(ny);
          osym_d = cmd_q.symbol; ovis_d = (cmd_q.symbol <= 8'h5A);
          oerr_d = ErrNone;
          pos_x_d = sat32(nx); pos_y_d = sat32(ny);
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      pos_x_q <= '0; pos_y_q <= '0; head_q <= '0; depth_q <= '0; ov_q <= 1'b0;
    end else begin
      state_q <= state_d;
      pos_x_q <= pos_x_d; pos_y_q <= pos_y_d; head_q <= head_d; depth_q <= depth_d;
      ov_q <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d; len_q <= len_d; cx_q <= cx_d; cy_q <= cy_d; cz_q <= cz_d;
    flip_q <= flip_d; step_q <= step_d; px_q <= px_d; py_q <= py_d;
    ofx_q <= ofx_d; ofy_q <= ofy_d; otx_q <= otx_d; oty_q <= oty_d;
    osym_q <= osym_d; ovis_q <= ovis_d; oerr_q <= oerr_d;
  end

  always_ff @(posedge clk_i) begin
    if (st_we) begin
      spos_mem[st_wa]  <= {bx, by};
      shead_mem[st_wa] <= bh;
    end
    spos_rd_q  <= spos_mem[st_ra];
    shead_rd_q <= shead_mem[st_ra];
  end

  a_depth_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    depth_q <= CntW'(StackDepth)) else $error("stack depth out of range");
  a_take_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_ready_o |-> state_q == StIdle && (!ov_q || out_ready))
    else $error("command taken while busy");
  a_err_no_vis: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ov_q && oerr_q != ErrNone |-> !ovis_q) else $error("error beat marked visible");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ov_q && !out_ready |=> ov_q && $stable(otx_q)) else $error("result dropped");

endmodule

[rtl/core/turtle_path_interpreter.sv]
// top level of the turtle path interpreter
// a letter goes from the input through the command queue and the multiply, cordic,
// product and sum states to its result beat; a stack error comes from the idle state
// a letter holds the shared cordic iteration until its sum state, a pop its stack read;
// turns, pushes and ignored symbols one per cycle unless a result beat is stalled
// reset: turtle at origin, heading 0, stack empty, registers at defaults
`timescale 1ns / 1ps
module turtle_path_interpreter import tpi_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               begin_req_i,
  input  logic [7:0]         symbol_i,
  input  logic               has_value_i,
  input  logic signed [23:0] value_i,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] from_x_o,
  output logic signed [31:0] from_y_o,
  output logic signed [31:0] to_x_o,
  output logic signed [31:0] to_y_o,
  output logic [7:0]         drawn_symbol_o,
  output logic               visible_o,
  output logic [1:0]         error_o,
  input  logic               cfg_we,
  input  logic [CfgAw-1:0]   cfg_index,
  input  logic [31:0]        cfg_wdata
);

  logic [23:0]        std_len_q;
  logic [15:0]        std_ang_q;
  logic signed [31:0] start_x_q, start_y_q;
  logic               cmd_valid, cmd_ready;
  cmd_t               cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      std_len_q <= 24'd65536;
      std_ang_q <= 16'd4096;
      start_x_q <= '0;
      start_y_q <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        RegStdLength: std_len_q <= cfg_wdata[23:0];
        RegStdAngle:  std_ang_q <= cfg_wdata[15:0];
        RegStartX:    start_x_q <= cfg_wdata;
        RegStartY:    start_y_q <= cfg_wdata;
        default: ;
      endcase
    end
  end

  tpi_front u_front (
    .clk_i, .rst_ni, .in_valid, .in_ready, .begin_req_i, .symbol_i, .has_value_i,
    .value_i, .cmd_valid_o(cmd_valid), .cmd_ready_i(cmd_ready), .cmd_o(cmd)
  );

  tpi_back u_back (
    .clk_i, .rst_ni, .cmd_valid_i(cmd_valid), .cmd_ready_o(cmd_ready), .cmd_i(cmd),
    .std_length_i(std_len_q), .std_angle_i(std_ang_q), .start_x_i(start_x_q),
    .start_y_i(start_y_q), .out_valid, .out_ready, .from_x_o, .from_y_o, .to_x_o,
    .to_y_o, .drawn_symbol_o, .visible_o, .error_o
  );

endmodule

[tb/tb.sv]
// self-checking testbench for the turtle path interpreter
`timescale 1ns / 1ps

typedef struct packed {
  logic [31:0] from_x;
  logic [31:0] from_y;
  logic [31:0] to_x;
  logic [31:0] to_y;
  logic [7:0]  sym;
  logic        vis;
  logic [1:0]  err;
} seg_t;

class segment_scoreboard;
  logic [23:0] std_length;
  logic [15:0] std_angle;
  logic signed [31:0] home_x, home_y;
  logic signed [31:0] pos_x, pos_y;
  logic [15:0] heading;
  logic [63:0] saved_pos [64];
  logic [15:0] saved_head [64];
  int unsigned depth;
  seg_t pending [$];
  int errors;

  function new();
    std_length = 24'd65536;
    std_angle = 16'd4096;
    home_x = 0;
    home_y = 0;
    pos_x = 0;
    pos_y = 0;
    heading = 0;
    depth = 0;
    errors = 0;
  endfunction

  function void set_reg(logic [1:0] idx, logic [31:0] data);
    case (idx)
      tpi_pkg::RegStdLength: std_length = data[23:0];
      tpi_pkg::RegStdAngle:  std_angle = data[15:0];
      tpi_pkg::RegStartX:    home_x = data;
      tpi_pkg::RegStartY:    home_y = data;
      default: ;
    endcase
  endfunction

  function void add_expected(seg_t s);
    pending.insert(pending.size(), s);
  endfunction

  function longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function void sin_cos(logic [15:0] ang, output longint c, output longint s);
    longint z, x, y, dx, dy;
    bit flip;
    z = longint'($signed({ang, 16'h0000}));
    flip = 0;
    x = 652032874;
    y = 0;
    if (z > 64'sh40000000) begin
      z -= 64'sh80000000;
      flip = 1;
    end else if (z < -64'sh40000000) begin
      z += 64'sh80000000;
      flip = 1;
    end
    for (int i = 0; i < 16; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= longint'(tpi_pkg::atan_lut(i[4:0]));
      end else begin
        x += dx; y -= dy; z += longint'(tpi_pkg::atan_lut(i[4:0]));
      end
    end
    if (flip) begin
      x = -x; y = -y;
    end
    c = x;
    s = y;
  endfunction

  function void note_input(bit beg, logic [7:0] sym, bit hv, logic signed [23:0] val);
    longint len, c, s, nx, ny;
    logic [15:0] amt;
    if (beg) begin
      pos_x = home_x; pos_y = home_y; heading = 0; depth = 0;
    end
    if ((sym >= "A" && sym <= "Z") || (sym >= "a" && sym <= "z")) begin
      if (hv) len = (longint'(val) * longint'({40'd0, std_length}) + 32768) >>> 16;
      else len = longint'({40'd0, std_length});
      sin_cos(heading, c, s);
      nx = clamp32(longint'(pos_x) + ((len * c + (64'sd1 <<< 29)) >>> 30));
      ny = clamp32(longint'(pos_y) - ((len * s + (64'sd1 <<< 29)) >>> 30));
      add_expected({pos_x, pos_y, nx[31:0], ny[31:0], sym, sym <= "Z", tpi_pkg::ErrNone});
      pos_x = nx[31:0];
      pos_y = ny[31:0];
    end else if (sym == tpi_pkg::SymPlus || sym == tpi_pkg::SymMinus) begin
      amt = hv ? val[15:0] : std_angle;
      heading = (sym == tpi_pkg::SymPlus) ? heading + amt : heading - amt;
    end else if (sym == tpi_pkg::SymPush) begin
      if (depth >= 64) begin
        add_expected({pos_x, pos_y, pos_x, pos_y, sym, 1'b0, tpi_pkg::ErrOverflow});
      end else begin
        saved_pos[depth] = {pos_x, pos_y};
        saved_head[depth] = heading;
        depth++;
      end
    end else if (sym == tpi_pkg::SymPop) begin
      if (depth == 0) begin
        add_expected({pos_x, pos_y, pos_x, pos_y, sym, 1'b0, tpi_pkg::ErrUnderflow});
      end else begin
        depth--;
        {pos_x, pos_y} = saved_pos[depth];
        heading = saved_head[depth];
      end
    end
  endfunction

  function void check_segment(seg_t got);
    seg_t want;
    if (pending.size() == 0) begin
      $error("segment with nothing pending: %h", got);
      errors++;
      return;
    end
    want = pending.pop_front();
    if (got.from_x !== want.from_x) begin
      $error("from_x exp %h got %h", want.from_x, got.from_x); errors++;
    end
    if (got.from_y !== want.from_y) begin
      $error("from_y exp %h got %h", want.from_y, got.from_y); errors++;
    end
    if (got.to_x !== want.to_x) begin
      $error("to_x exp %h got %h", want.to_x, got.to_x); errors++;
    end
    if (got.to_y !== want.to_y) begin
      $error("to_y exp %h got %h", want.to_y, got.to_y); errors++;
    end
    if (got.sym !== want.sym) begin
      $error("drawn_symbol exp %h got %h", want.sym, got.sym); errors++;
    end
    if (got.vis !== want.vis) begin
      $error("visible exp %h got %h", want.vis, got.vis); errors++;
    end
    if (got.err !== want.err) begin
      $error("error exp %h got %h", want.err, got.err); errors++;
    end
  endfunction
endclass

module tb;
  import tpi_pkg::*;

  logic clk_i, rst_ni;
  logic in_valid, in_ready, out_valid, out_ready;
  logic begin_req_i, has_value_i;
  logic [7:0] symbol_i;
  logic signed [23:0] value_i;
  logic signed [31:0] from_x_o, from_y_o, to_x_o, to_y_o;
  logic [7:0] drawn_symbol_o;
  logic visible_o;
  logic [1:0] error_o;
  logic cfg_we;
  logic [CfgAw-1:0] cfg_index;
  logic [31:0] cfg_wdata;
  int cycles = 0;
  bit calm;
  segment_scoreboard sb;

  turtle_path_interpreter i_dut (.*);

  always begin
    clk_i = 1'b1; #5;
    clk_i = 1'b0; #5;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > 600000) begin
      $display("tb failed");
      $finish;
    end
  end

  // sink side: check and throttle
  always @(posedge clk_i) begin
    if (rst_ni && out_valid && out_ready)
      sb.check_segment({from_x_o, from_y_o, to_x_o, to_y_o, drawn_symbol_o,
                        visible_o, error_o});
  end

  always @(negedge clk_i) out_ready <= calm ? 1'b1 : ($urandom_range(99) >= 25);

  task automatic send(bit beg, logic [7:0] sym, bit hv, logic signed [23:0] val);
    while (!calm && $urandom_range(99) < 25) begin
      in_valid <= 1'b0;
      @(negedge clk_i);
    end
    begin_req_i <= beg; symbol_i <= sym; has_value_i <= hv; value_i <= val;
    in_valid <= 1'b1;
    do @(posedge clk_i); while (!in_ready);
    sb.note_input(beg, sym, hv, val);
    @(negedge clk_i);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(negedge clk_i);
    repeat (40) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] data);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_wdata <= data;
    sb.set_reg(idx, data);
    @(negedge clk_i);
    cfg_we <= 1'b0;
    @(negedge clk_i);
  endtask

  function automatic logic [7:0] pick_symbol();
    int r;
    r = $urandom_range(99);
    if (r < 30) return $urandom_range(1) ? 8'($urandom_range(65, 90)) : 8'($urandom_range(97, 122));
    if (r < 50) return $urandom_range(1) ? SymPlus : SymMinus;
    if (r < 67) return SymPush;
    if (r < 84) return SymPop;
    return 8'($urandom_range(255));
  endfunction

  initial begin
    sb = new();
    calm = 1'b0;
    in_valid = 0; begin_req_i = 0; symbol_i = 0; has_value_i = 0; value_i = 0;
    cfg_we = 0; cfg_index = 0; cfg_wdata = 0;
    rst_ni = 1'b0;
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;
    // directed
    send(1, "F", 0, 0);
    send(0, "f", 1, 24'sh7FFFFF);
    send(0, "Z", 1, -24'sh800000);
    send(0, SymPlus, 0, 0);
    send(0, "A", 0, 0);
    send(0, SymMinus, 1, 24'sh00C000);
    send(0, "z", 0, 0);
    send(0, SymPop, 0, 0);
    send(0, SymPush, 0, 0);
    send(0, SymPlus, 1, 24'sh008000);
    send(0, "G", 1, 24'sh010000);
    send(0, SymPop, 0, 0);
    send(0, 8'hFF, 1, 24'sh123456);
    send(0, 8'h00, 0, 0);
    for (int i = 0; i < 65; i++) send(0, SymPush, 0, 0);
    drain();
    write_reg(RegStdLength, 32'hFFFFFF);
    write_reg(RegStdAngle, 32'hFFFF);
    write_reg(RegStartX, 32'h7FFF0000);
    write_reg(RegStartY, 32'h80000000);
    send(1, "X", 1, 24'sh7FFFFF);
    send(0, SymMinus, 0, 0);
    send(0, "x", 1, -24'sh800000);
    drain();
    for (int ph = 0; ph < 4; ph++) begin
      write_reg(RegStdLength, ph == 0 ? 32'd0 : 32'($urandom_range(24'hFFFFFF)));
      write_reg(RegStdAngle, ph == 1 ? 32'd0 : 32'($urandom_range(16'hFFFF)));
      write_reg(RegStartX, $urandom);
      write_reg(RegStartY, $urandom);
      calm = (ph == 2);
      for (int n = 0; n < 330; n++)
        send($urandom_range(49) == 0, pick_symbol(), $urandom_range(1),
             24'($urandom));
      drain();
    end
    if (sb.errors == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end
endmodule
